@@ rtl/arrhenius_power_law_viscosity_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Arrhenius power-law viscosity block
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ARRHENIUS_POWER_LAW_VISCOSITY_ASSERT_SVH
`define ARRHENIUS_POWER_LAW_VISCOSITY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APLV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APLV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aplv_pkg.sv @@
// ----------------------------------------------------------------------------
// aplv_pkg
// Types, constants and constant tables for the viscosity pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aplv_pkg;

    localparam int TEMP_FRAC_BITS_DEF = 16;

    localparam int TEMP_W     = 32;
    localparam int VISC_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int FLOW_FRAC = 28;

    // Log-domain magnitudes saturate at 2^42.
    localparam int             CAP_W   = 43;
    localparam logic [42:0]    LOG_CAP = {1'b1, 42'd0};
    localparam logic [32:0]    LOG2E   = 33'h171547653;

    // log2 unit: 48-bit input, leading-one search then 32 squarings.
    localparam int LOG_IN_W        = 48;
    localparam int LOG_NORM_STAGES = $clog2(LOG_IN_W);
    localparam int LOG_FRAC_W      = 32;
    localparam int LOG_W           = LOG_NORM_STAGES + LOG_FRAC_W;
    localparam int LOG_LAT         = LOG_NORM_STAGES + LOG_FRAC_W;

    // exp2 unit: Q1.30 mantissa over 30 fraction bits.
    localparam int EXP_STEPS = 30;
    localparam int MANT_W    = 31;

    localparam logic [47:0] RST_REF_VISC   = 48'd4294967296;
    localparam logic [31:0] RST_ACT_TEMP   = 32'd0;
    localparam logic [31:0] RST_REF_TEMP   = 32'd19660800;
    localparam logic [31:0] RST_FLOW_INDEX = 32'd268435456;
    localparam logic [47:0] RST_MIN_VISC   = 48'd0;
    localparam logic [47:0] RST_MAX_VISC   = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_VISC,
        REG_ACT_TEMP,
        REG_REF_TEMP,
        REG_FLOW_INDEX,
        REG_MIN_VISC,
        REG_MAX_VISC
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_NONE,
        STATUS_MIN,
        STATUS_MAX
    } clamp_status_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [TEMP_W-1:0] strain_rate;
    } visc_req_t;

    typedef struct packed {
        logic [VISC_W-1:0] viscosity;
        clamp_status_t     clamp_status;
    } visc_rsp_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] b;
        r   = '0;
        rem = v;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // c_k = 2^(2^-k) in Q2.30, each the truncated root of the one before.
    function automatic logic [EXP_STEPS:1][31:0] exp_coef_table();
        logic [EXP_STEPS:1][31:0] tab;
        logic [63:0]              c;
        c = 64'd1 << 31;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            c      = isqrt64(c << 30);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam logic [EXP_STEPS:1][31:0] EXP_COEF = exp_coef_table();

endpackage

@@ rtl/arrhenius_power_law_viscosity.sv @@
// ----------------------------------------------------------------------------
// arrhenius_power_law_viscosity
// Per-cell viscosity kref*exp(sk*(1/T-1/tref))*rate^(n-1), clamped.
// ----------------------------------------------------------------------------
// A request (temperature, strain rate) is taken at every rising edge where
// start is high and busy is low; busy stays low, so one request per cycle is
// taken without gaps. Each result appears on result for one cycle with done
// high, in request order. The path runs through the two pipelined reciprocal
// dividers (TEMP_FRAC_BITS + 33 stages, one quotient bit each), the product
// stages after them, the 30 multiply stages of the exp2 unit and the shift and
// clamp stages. The log2 units run beside the dividers. The result receiver
// cannot stall, so the pipeline simply advances every cycle. Registers are
// written through cfg_en/cfg_index/cfg_data; the user must write them only
// while no request is in flight, which the block itself does not enforce.
// Reset clears the valid bits and loads the register defaults; items in
// flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arrhenius_power_law_viscosity_assert.svh"

module arrhenius_power_law_viscosity #(
    parameter int TEMP_FRAC_BITS = aplv_pkg::TEMP_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  aplv_pkg::visc_req_t                cmd,
    input  logic [aplv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                               cfg_en,
    input  logic [aplv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               done,
    output aplv_pkg::visc_rsp_t                result
);

    localparam int QW    = TEMP_FRAC_BITS + 33;
    localparam int LL    = aplv_pkg::LOG_LAT;
    localparam int DP    = QW + 2 - LL;
    localparam int DK    = QW + 5 - LL;
    localparam int XP_W  = QW + 32;
    localparam int NS    = aplv_pkg::EXP_STEPS;
    localparam int MW    = aplv_pkg::MANT_W;
    localparam int S_X1  = QW + 1;
    localparam int S_E   = QW + 6;
    localparam int S_M   = S_E + NS;
    localparam int LAT   = S_M + 2;
    localparam logic [39:0] LG_OFS = 40'(TEMP_FRAC_BITS) << 32;

    // Configuration registers.
    logic [47:0] ref_visc_reg;
    logic [31:0] act_temp_reg;
    logic [31:0] ref_temp_reg;
    logic [31:0] flow_index_reg;
    logic [47:0] min_visc_reg;
    logic [47:0] max_visc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ref_visc_reg   <= aplv_pkg::RST_REF_VISC;
            act_temp_reg   <= aplv_pkg::RST_ACT_TEMP;
            ref_temp_reg   <= aplv_pkg::RST_REF_TEMP;
            flow_index_reg <= aplv_pkg::RST_FLOW_INDEX;
            min_visc_reg   <= aplv_pkg::RST_MIN_VISC;
            max_visc_reg   <= aplv_pkg::RST_MAX_VISC;
        end
        else if (cfg_en) begin
            case (cfg_index)
                aplv_pkg::REG_REF_VISC:   ref_visc_reg   <= cfg_data;
                aplv_pkg::REG_ACT_TEMP:   act_temp_reg   <= cfg_data[31:0];
                aplv_pkg::REG_REF_TEMP:   ref_temp_reg   <= cfg_data[31:0];
                aplv_pkg::REG_FLOW_INDEX: flow_index_reg <= cfg_data[31:0];
                aplv_pkg::REG_MIN_VISC:   min_visc_reg   <= cfg_data;
                aplv_pkg::REG_MAX_VISC:   max_visc_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid line, one bit per pipeline stage.
    logic v_reg [LAT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= LAT; k++) begin
                v_reg[k] <= 1'b0;
            end
        end
        else begin
            v_reg[0] <= accept;
            for (int k = 1; k <= LAT; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Stage 0: capture, zero inputs become one LSB.
    logic [31:0] t0_reg, g0_reg, r0_reg;
    logic [47:0] k0_reg;

    always_ff @(posedge clk)
    begin
        t0_reg <= (cmd.temperature == '0) ? 32'd1 : cmd.temperature;
        g0_reg <= (cmd.strain_rate == '0) ? 32'd1 : cmd.strain_rate;
        r0_reg <= (ref_temp_reg == '0) ? 32'd1 : ref_temp_reg;
        k0_reg <= ref_visc_reg;
    end

    logic [QW-1:0]               qt, qr;
    logic [aplv_pkg::LOG_W-1:0]  g_log, k_log;

    aplv_recip #(.QW(QW)) u_recip_t (.clk(clk), .den(t0_reg), .quo(qt));
    aplv_recip #(.QW(QW)) u_recip_r (.clk(clk), .den(r0_reg), .quo(qr));
    aplv_log2 u_log_g (.clk(clk), .value({16'd0, g0_reg}), .log_val(g_log));
    aplv_log2 u_log_k (.clk(clk), .value(k0_reg), .log_val(k_log));

    // Temperature term: x = sk*d, then x*log2(e).
    logic [QW-1:0]   x1_dm_reg, x1_dm_next;
    logic [31:0]     x1_skm_reg, x1_skm_next;
    logic            x1_neg_reg, x1_neg_next;
    logic [63:0]     x2_lo_reg;
    logic [QW-1:0]   x2_hi_reg;
    logic            x2_neg_reg;
    logic [42:0]     x3_xm_reg, x3_xm_next;
    logic            x3_neg_reg;
    logic [64:0]     x4_lo_reg;
    logic [43:0]     x4_hi_reg;
    logic            x4_neg_reg;
    logic [42:0]     x5_xl_reg, x5_xl_next;
    logic            x5_neg_reg;

    always_comb
    begin
        logic [QW:0]     dd;
        logic [31:0]     skn;
        logic [XP_W-1:0] xsum;
        logic [XP_W-1:0] xsh;
        logic [76:0]     lsum;
        logic [76:0]     lsh;
        dd          = {1'b0, qt} - {1'b0, qr};
        x1_dm_next  = dd[QW] ? QW'(-dd) : dd[QW-1:0];
        skn         = -act_temp_reg;
        x1_skm_next = act_temp_reg[31] ? skn : act_temp_reg;
        x1_neg_next = act_temp_reg[31] ^ dd[QW];
        xsum        = XP_W'(x2_lo_reg) + {x2_hi_reg, 32'd0};
        xsh         = xsum >> TEMP_FRAC_BITS;
        x3_xm_next  = (xsh > XP_W'(aplv_pkg::LOG_CAP)) ? aplv_pkg::LOG_CAP : xsh[42:0];
        lsum        = 77'(x4_lo_reg) + 77'({x4_hi_reg, 32'd0});
        lsh         = lsum >> 32;
        x5_xl_next  = (lsh > 77'(aplv_pkg::LOG_CAP)) ? aplv_pkg::LOG_CAP : lsh[42:0];
    end

    always_ff @(posedge clk)
    begin
        x1_dm_reg  <= x1_dm_next;
        x1_skm_reg <= x1_skm_next;
        x1_neg_reg <= x1_neg_next;
        x2_lo_reg  <= 64'(x1_skm_reg) * 64'(x1_dm_reg[31:0]);
        x2_hi_reg  <= QW'(QW'(x1_skm_reg) * QW'(x1_dm_reg[QW-1:32]));
        x2_neg_reg <= x1_neg_reg;
        x3_xm_reg  <= x3_xm_next;
        x3_neg_reg <= x2_neg_reg;
        x4_lo_reg  <= 65'(x3_xm_reg[31:0]) * 65'(aplv_pkg::LOG2E);
        x4_hi_reg  <= 44'(x3_xm_reg[42:32]) * 44'(aplv_pkg::LOG2E);
        x4_neg_reg <= x3_neg_reg;
        x5_xl_reg  <= x5_xl_next;
        x5_neg_reg <= x4_neg_reg;
    end

    // Rate term: (n-1)*log2(g).
    logic [36:0] p1_lgm_reg, p1_lgm_next;
    logic [31:0] p1_nm_reg, p1_nm_next;
    logic        p1_neg_reg, p1_neg_next;
    logic [63:0] p2_lo_reg;
    logic [36:0] p2_hi_reg;
    logic        p2_neg_reg;
    logic [42:0] p3_pl_reg, p3_pl_next;
    logic        p3_neg_reg;

    always_comb
    begin
        logic [39:0] lgs;
        logic [39:0] lgn;
        logic [32:0] n1;
        logic [32:0] n1n;
        logic [69:0] psum;
        logic [69:0] psh;
        lgs         = {2'b00, g_log} - LG_OFS;
        lgn         = -lgs;
        p1_lgm_next = lgs[39] ? lgn[36:0] : lgs[36:0];
        n1          = {flow_index_reg[31], flow_index_reg} - (33'd1 << aplv_pkg::FLOW_FRAC);
        n1n         = -n1;
        p1_nm_next  = n1[32] ? n1n[31:0] : n1[31:0];
        p1_neg_next = lgs[39] ^ n1[32];
        psum        = 70'(p2_lo_reg) + 70'({p2_hi_reg, 32'd0});
        psh         = psum >> aplv_pkg::FLOW_FRAC;
        p3_pl_next  = (psh > 70'(aplv_pkg::LOG_CAP)) ? aplv_pkg::LOG_CAP : psh[42:0];
    end

    always_ff @(posedge clk)
    begin
        p1_lgm_reg <= p1_lgm_next;
        p1_nm_reg  <= p1_nm_next;
        p1_neg_reg <= p1_neg_next;
        p2_lo_reg  <= 64'(p1_nm_reg) * 64'(p1_lgm_reg[31:0]);
        p2_hi_reg  <= 37'(p1_nm_reg) * 37'(p1_lgm_reg[36:32]);
        p2_neg_reg <= p1_neg_reg;
        p3_pl_reg  <= p3_pl_next;
        p3_neg_reg <= p2_neg_reg;
    end

    // Align the rate term and log2(kref) with the temperature term.
    logic [42:0]                pl_dly_reg  [DP];
    logic                       pn_dly_reg  [DP];
    logic [aplv_pkg::LOG_W-1:0] kl_dly_reg  [DK];

    always_ff @(posedge clk)
    begin
        pl_dly_reg[0] <= p3_pl_reg;
        pn_dly_reg[0] <= p3_neg_reg;
        kl_dly_reg[0] <= k_log;
        for (int i = 1; i < DP; i++) begin
            pl_dly_reg[i] <= pl_dly_reg[i-1];
            pn_dly_reg[i] <= pn_dly_reg[i-1];
        end
        for (int i = 1; i < DK; i++) begin
            kl_dly_reg[i] <= kl_dly_reg[i-1];
        end
    end

    // Exponent sum in signed Q.32.
    logic [45:0] e_reg, e_next;

    always_comb
    begin
        logic [45:0] xv;
        logic [45:0] pv;
        xv     = x5_neg_reg ? -46'(x5_xl_reg) : 46'(x5_xl_reg);
        pv     = pn_dly_reg[DP-1] ? -46'(pl_dly_reg[DP-1]) : 46'(pl_dly_reg[DP-1]);
        e_next = 46'(kl_dly_reg[DK-1]) + xv + pv;
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

    // exp2: one coefficient multiply per fraction bit, for all but the lowest two.
    logic [MW-1:0] m_reg   [1:NS];
    logic [MW-1:0] m_next  [1:NS];
    logic [31:0]   fp_reg  [1:NS];
    logic [5:0]    ip_reg  [1:NS];
    logic          ovf_reg [1:NS];
    logic          unf_reg [1:NS];

    function automatic logic [MW-1:0] exp_step(input logic [MW-1:0] m, input logic sel,
                                               input logic [31:0] c);
        logic [62:0] prod;
        prod = 63'(m) * 63'(c);
        return sel ? prod[60:30] : m;
    endfunction

    always_comb
    begin
        m_next[1] = exp_step(MW'(1) << 30, e_reg[31], aplv_pkg::EXP_COEF[1]);
        for (int k = 2; k <= NS; k++) begin
            m_next[k] = exp_step(m_reg[k-1], fp_reg[k-1][32-k], aplv_pkg::EXP_COEF[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[1]   <= m_next[1];
        fp_reg[1]  <= e_reg[31:0];
        ip_reg[1]  <= e_reg[37:32];
        // Integer part at least 48 saturates; a negative one underflows to zero.
        ovf_reg[1] <= !e_reg[45] && (e_reg[44:32] >= 13'd48);
        unf_reg[1] <= e_reg[45];
        for (int k = 2; k <= NS; k++) begin
            m_reg[k]   <= m_next[k];
            fp_reg[k]  <= fp_reg[k-1];
            ip_reg[k]  <= ip_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            unf_reg[k] <= unf_reg[k-1];
        end
    end

    // Final shift, then clamp.
    logic [47:0] sh_nu_reg, sh_nu_next;

    always_comb
    begin
        logic [77:0] wide;
        wide = 78'(m_reg[NS]) << ip_reg[NS];
        if (ref_visc_reg == '0) begin
            sh_nu_next = '0;
        end
        else if (ovf_reg[NS]) begin
            sh_nu_next = '1;
        end
        else if (unf_reg[NS]) begin
            sh_nu_next = '0;
        end
        else begin
            sh_nu_next = wide[77:30];
        end
    end

    aplv_pkg::visc_rsp_t rsp_reg, rsp_next;

    always_comb
    begin
        rsp_next.viscosity    = sh_nu_reg;
        rsp_next.clamp_status = aplv_pkg::STATUS_NONE;
        if (sh_nu_reg > max_visc_reg) begin
            rsp_next.viscosity    = max_visc_reg;
            rsp_next.clamp_status = aplv_pkg::STATUS_MAX;
        end
        if (rsp_next.viscosity < min_visc_reg) begin
            rsp_next.viscosity    = min_visc_reg;
            rsp_next.clamp_status = aplv_pkg::STATUS_MIN;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_nu_reg <= sh_nu_next;
        rsp_reg   <= rsp_next;
    end

    assign done   = v_reg[LAT];
    assign result = rsp_reg;

    `APLV_ASSERT_IMP(a_latency, done, $past(v_reg[0], LAT),
        "result strobe without a request at the pipeline latency")
    `APLV_ASSERT_NXT(a_underflow, v_reg[S_M] && unf_reg[NS], sh_nu_reg == '0,
        "negative exponent did not give a zero viscosity")

endmodule

@@ rtl/aplv_recip.sv @@
// ----------------------------------------------------------------------------
// aplv_recip
// Pipelined restoring divider: floor(2^(QW-1) / den), one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aplv_recip #(
    parameter int QW = aplv_pkg::TEMP_FRAC_BITS_DEF + 33
) (
    input  logic          clk,
    input  logic [31:0]   den,
    output logic [QW-1:0] quo
);

    logic [31:0]   rem_reg  [QW];
    logic [31:0]   rem_next [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [QW-1:0] q_next   [QW];
    logic [31:0]   den_reg  [QW];

    // The dividend is a single one at its top bit, so only stage 0 shifts in a one.
    function automatic logic [32+QW-1:0] div_step(input logic [31:0] rem,
                                                  input logic din,
                                                  input logic [31:0] dv,
                                                  input logic [QW-1:0] q);
        logic [32:0] sh;
        logic [32:0] df;
        sh = {rem, din};
        df = sh - {1'b0, dv};
        if (sh >= {1'b0, dv}) begin
            return {df[31:0], q[QW-2:0], 1'b1};
        end
        return {sh[31:0], q[QW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        {rem_next[0], q_next[0]} = div_step(32'd0, 1'b1, den, '0);
        for (int k = 1; k < QW; k++) begin
            {rem_next[k], q_next[k]} = div_step(rem_reg[k-1], 1'b0, den_reg[k-1], q_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int k = 0; k < QW; k++) begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
        end
        for (int k = 1; k < QW; k++) begin
            den_reg[k] <= den_reg[k-1];
        end
    end

    assign quo = q_reg[QW-1];

endmodule

@@ rtl/aplv_log2.sv @@
// ----------------------------------------------------------------------------
// aplv_log2
// Pipelined base-2 logarithm: leading-one search, then one squaring a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aplv_log2 (
    input  logic                       clk,
    input  logic [aplv_pkg::LOG_IN_W-1:0] value,
    output logic [aplv_pkg::LOG_W-1:0]    log_val
);

    localparam int IW  = aplv_pkg::LOG_IN_W;
    localparam int LZW = aplv_pkg::LOG_NORM_STAGES;
    localparam int FW  = aplv_pkg::LOG_FRAC_W;

    logic [IW-1:0]  n_reg   [LZW];
    logic [IW-1:0]  n_next  [LZW];
    logic [LZW-1:0] lz_reg  [LZW];
    logic [LZW-1:0] lz_next [LZW];

    logic [31:0]    m_reg   [FW];
    logic [31:0]    m_next  [FW];
    logic [FW-1:0]  f_reg   [FW];
    logic [FW-1:0]  f_next  [FW];
    logic [LZW-1:0] p_reg   [FW];
    logic [LZW-1:0] p_next  [FW];

    // Stage j shifts left by 2^(LZW-1-j) when that many top bits are zero.
    function automatic logic [IW+LZW-1:0] norm_step(input logic [IW-1:0] src,
                                                    input logic [LZW-1:0] lz,
                                                    input int j);
        int             s;
        logic [IW-1:0]  n;
        logic [LZW-1:0] z;
        s = 1 << (LZW - 1 - j);
        n = src;
        z = lz;
        if ((src >> (IW - s)) == '0) begin
            n = src << s;
            z[LZW-1-j] = 1'b1;
        end
        return {n, z};
    endfunction

    function automatic logic [32+FW-1:0] sq_step(input logic [31:0] m,
                                                 input logic [FW-1:0] f);
        logic [63:0] sq;
        sq = 64'(m) * 64'(m);
        if (sq[63]) begin
            return {sq[63:32], f[FW-2:0], 1'b1};
        end
        return {sq[62:31], f[FW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        {n_next[0], lz_next[0]} = norm_step(value, '0, 0);
        for (int j = 1; j < LZW; j++) begin
            {n_next[j], lz_next[j]} = norm_step(n_reg[j-1], lz_reg[j-1], j);
        end
        p_next[0] = LZW'(IW - 1) - lz_reg[LZW-1];
        {m_next[0], f_next[0]} = sq_step(n_reg[LZW-1][IW-1 -: 32], '0);
        for (int i = 1; i < FW; i++) begin
            p_next[i] = p_reg[i-1];
            {m_next[i], f_next[i]} = sq_step(m_reg[i-1], f_reg[i-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LZW; j++) begin
            n_reg[j]  <= n_next[j];
            lz_reg[j] <= lz_next[j];
        end
        for (int i = 0; i < FW; i++) begin
            m_reg[i] <= m_next[i];
            f_reg[i] <= f_next[i];
            p_reg[i] <= p_next[i];
        end
    end

    assign log_val = {p_reg[FW-1], f_reg[FW-1]};

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for arrhenius_power_law_viscosity
// Drives cell requests under several register settings, predicts each
// clamped viscosity in the log2 domain, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam longint ONE_Q32 = 64'sd4294967296;
    localparam logic [47:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    aplv_pkg::visc_req_t   cmd;
    logic [aplv_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic                            cfg_en;
    logic [aplv_pkg::CFG_DATA_W-1:0] cfg_data;
    logic        done;
    aplv_pkg::visc_rsp_t   result;

    // Register copies used by the predictor.
    logic [47:0] kref;
    logic [31:0] sk_raw;
    logic [31:0] tref;
    logic [31:0] n_raw;
    logic [47:0] nu_min;
    logic [47:0] nu_max;

    aplv_pkg::visc_req_t   pending_cells[$];
    aplv_pkg::visc_rsp_t   expected_visc[$];
    logic        taken;
    int          sender_idle_pct;
    int          errors;
    int          cells_sent;
    int          results_seen;

    arrhenius_power_law_viscosity u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_index (cfg_index),
        .cfg_en    (cfg_en),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mul_shift_cap(input logic [63:0] a, input logic [63:0] b,
                                                  input int sh, input logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Signed Q.32 log2 of a nonzero raw value by repeated squaring.
    function automatic longint log2_fixed(input logic [63:0] u);
        int          p;
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] frac;
        p = 0;
        frac = 0;
        for (int i = 63; i >= 0; i--)
        begin
            if (u[i] && p == 0 && u >> i == 64'd1)
                p = i;
        end
        m = (p >= 31) ? (u >> (p - 31)) : (u << (31 - p));
        for (int i = 0; i < 32; i++)
        begin
            sq = m * m;
            frac = frac << 1;
            if (sq[63])
            begin
                frac[0] = 1'b1;
                m = sq >> 32;
            end
            else
            begin
                m = sq >> 31;
            end
        end
        return longint'(p) * ONE_Q32 + longint'(frac);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bitv;
        r = 0;
        rem = v;
        for (int i = 31; i >= 0; i--)
        begin
            bitv = 64'd1 << (2 * i);
            if (rem >= r + bitv)
            begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [47:0] exp2_fixed(input longint e);
        longint      ip;
        logic [63:0] fp;
        logic [63:0] m;
        logic [63:0] c;
        m = 64'd1 << 30;
        c = 64'd1 << 31;
        if (e >= 0)
            ip = e >>> 32;
        else
            ip = -longint'((abs64(e) + 64'hFFFF_FFFF) >> 32);
        fp = 64'(e - ip * ONE_Q32);
        if (ip >= 48)
            return ALL_ONES48;
        if (ip < 0)
            return 48'd0;
        for (int k = 1; k <= 30; k++)
        begin
            c = int_sqrt(c << 30);
            if (fp[32 - k])
                m = (m * c) >> 30;
        end
        if (ip >= 30)
            return 48'(m << (ip - 30));
        return 48'(m >> (30 - ip));
    endfunction

    function automatic aplv_pkg::visc_rsp_t predict_viscosity(input aplv_pkg::visc_req_t rq);
        logic [63:0] t;
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] num;
        longint      d;
        longint      sk;
        longint      n1;
        longint      lg;
        longint      e;
        logic [63:0] xm;
        logic [63:0] xl;
        logic [63:0] pl;
        logic [47:0] nu;
        aplv_pkg::visc_rsp_t rsp;
        t = (rq.temperature == 0) ? 64'd1 : 64'(rq.temperature);
        g = (rq.strain_rate == 0) ? 64'd1 : 64'(rq.strain_rate);
        r = (tref == 0) ? 64'd1 : 64'(tref);
        num = 64'd1 << 48;
        d = longint'(num / t) - longint'(num / r);
        sk = longint'(signed'(sk_raw));
        xm = mul_shift_cap(abs64(sk), abs64(d), 16, 64'(aplv_pkg::LOG_CAP));
        xl = mul_shift_cap(xm, 64'(aplv_pkg::LOG2E), 32, 64'(aplv_pkg::LOG_CAP));
        n1 = longint'(signed'(n_raw)) - (64'sd1 <<< aplv_pkg::FLOW_FRAC);
        lg = log2_fixed(g) - 16 * ONE_Q32;
        pl = mul_shift_cap(abs64(n1), abs64(lg), aplv_pkg::FLOW_FRAC,
                           64'(aplv_pkg::LOG_CAP));
        if (kref == 0)
        begin
            nu = 48'd0;
        end
        else
        begin
            e = log2_fixed(64'(kref));
            e += (((sk < 0) != (d < 0)) ? -longint'(xl) : longint'(xl));
            e += (((n1 < 0) != (lg < 0)) ? -longint'(pl) : longint'(pl));
            nu = exp2_fixed(e);
        end
        rsp.clamp_status = aplv_pkg::STATUS_NONE;
        if (nu > nu_max)
        begin
            nu = nu_max;
            rsp.clamp_status = aplv_pkg::STATUS_MAX;
        end
        if (nu < nu_min)
        begin
            nu = nu_min;
            rsp.clamp_status = aplv_pkg::STATUS_MIN;
        end
        rsp.viscosity = nu;
        return rsp;
    endfunction

    // Request driver: holds a request until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            taken = 1'b0;
            if (pending_cells.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                cmd   <= pending_cells.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: records taken requests and checks each result.
    always @(posedge clk)
    begin
        aplv_pkg::visc_rsp_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken = 1'b1;
                expected_visc.push_back(predict_viscosity(cmd));
                cells_sent++;
            end
            if (done)
            begin
                results_seen++;
                if (expected_visc.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_visc.pop_front();
                    if (result.viscosity !== want.viscosity)
                    begin
                        $error("viscosity expected %h actual %h",
                               want.viscosity, result.viscosity);
                        errors++;
                    end
                    if (result.clamp_status !== want.clamp_status)
                    begin
                        $error("clamp_status expected %0d actual %0d",
                               want.clamp_status, result.clamp_status);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input aplv_pkg::cfg_reg_t idx, input logic [47:0] val);
        @(negedge clk);
        cfg_en    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            aplv_pkg::REG_REF_VISC:   kref   = val;
            aplv_pkg::REG_ACT_TEMP:   sk_raw = val[31:0];
            aplv_pkg::REG_REF_TEMP:   tref   = val[31:0];
            aplv_pkg::REG_FLOW_INDEX: n_raw  = val[31:0];
            aplv_pkg::REG_MIN_VISC:   nu_min = val;
            default:                  nu_max = val;
        endcase
        @(negedge clk);
        cfg_en = 1'b0;
    endtask

    function automatic logic [31:0] wide_value();
        return $urandom >> $urandom_range(31);
    endfunction

    task automatic queue_cell(input logic [31:0] t, input logic [31:0] g);
        aplv_pkg::visc_req_t rq;
        rq.temperature = t;
        rq.strain_rate = g;
        pending_cells.push_back(rq);
    endtask

    // Let everything queued go through and every result come back. The check
    // runs at the rising edge, where the driver's outputs are settled.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_cells.size() != 0 || start || expected_visc.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_cells(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 7)
                queue_cell(32'($urandom_range(150, 900)) << 16 | ($urandom & 32'hFFFF),
                           wide_value());
            else
                queue_cell(wide_value(), wide_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        taken = 1'b0;
        sender_idle_pct = 26;
        errors = 0;
        cells_sent = 0;
        results_seen = 0;
        kref = aplv_pkg::RST_REF_VISC;
        sk_raw = aplv_pkg::RST_ACT_TEMP;
        tref = aplv_pkg::RST_REF_TEMP;
        n_raw = aplv_pkg::RST_FLOW_INDEX;
        nu_min = aplv_pkg::RST_MIN_VISC;
        nu_max = aplv_pkg::RST_MAX_VISC;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes under the reset setting, then a live setting.
        queue_cell(32'd0, 32'd0);
        queue_cell(32'd1, 32'd1);
        queue_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cell(32'd19660800, 32'd65536);
        drain();
        write_reg(aplv_pkg::REG_ACT_TEMP, 48'(32'd3000 << 16));
        write_reg(aplv_pkg::REG_FLOW_INDEX, 48'(32'd1 << 27));
        write_reg(aplv_pkg::REG_MIN_VISC, 48'd1 << 20);
        write_reg(aplv_pkg::REG_MAX_VISC, 48'd1 << 40);
        queue_cell(32'd0, 32'd0);
        queue_cell(32'd1, 32'hFFFF_FFFF);
        queue_cell(32'hFFFF_FFFF, 32'd1);
        queue_cell(32'd19660800, 32'd65536);
        queue_cell(32'd400 << 16, 32'd0);
        queue_cell(32'd250 << 16, 32'd1000 << 16);
        drain();
        // Zero scale, zero reference temperature, minimum above maximum.
        write_reg(aplv_pkg::REG_REF_VISC, 48'd0);
        write_reg(aplv_pkg::REG_REF_TEMP, 48'd0);
        queue_cell(32'd300 << 16, 32'd5 << 16);
        queue_cell(32'd1, 32'd1);
        drain();
        write_reg(aplv_pkg::REG_REF_VISC, ALL_ONES48);
        write_reg(aplv_pkg::REG_ACT_TEMP, 48'h7FFF_FFFF);
        write_reg(aplv_pkg::REG_FLOW_INDEX, 48'h8000_0000);
        write_reg(aplv_pkg::REG_MIN_VISC, 48'd1 << 45);
        write_reg(aplv_pkg::REG_MAX_VISC, 48'd1 << 30);
        queue_cell(32'd1, 32'd1);
        queue_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cell(32'd300 << 16, 32'd2 << 16);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++)
        begin
            sender_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 56 : 0;
            case (ph)
                0:
                begin
                    write_reg(aplv_pkg::REG_REF_VISC, aplv_pkg::RST_REF_VISC);
                    write_reg(aplv_pkg::REG_ACT_TEMP, 48'(32'd2000 << 16));
                    write_reg(aplv_pkg::REG_REF_TEMP, 48'(aplv_pkg::RST_REF_TEMP));
                    write_reg(aplv_pkg::REG_FLOW_INDEX, 48'(32'd3 << 26));
                    write_reg(aplv_pkg::REG_MIN_VISC, 48'd1 << 16);
                    write_reg(aplv_pkg::REG_MAX_VISC, 48'd1 << 38);
                end
                1:
                begin
                    write_reg(aplv_pkg::REG_REF_VISC, 48'd1);
                    write_reg(aplv_pkg::REG_ACT_TEMP, 48'h8000_0000);
                    write_reg(aplv_pkg::REG_REF_TEMP, 48'hFFFF_FFFF);
                    write_reg(aplv_pkg::REG_FLOW_INDEX, 48'h7FFF_FFFF);
                    write_reg(aplv_pkg::REG_MIN_VISC, 48'd0);
                    write_reg(aplv_pkg::REG_MAX_VISC, ALL_ONES48);
                end
                default:
                begin
                    write_reg(aplv_pkg::REG_REF_VISC,
                              48'({$urandom, $urandom} >> $urandom_range(47)));
                    write_reg(aplv_pkg::REG_ACT_TEMP,
                              48'(32'($signed($urandom) >>> $urandom_range(31))));
                    write_reg(aplv_pkg::REG_REF_TEMP, 48'($urandom_range(100, 1000)) << 16);
                    write_reg(aplv_pkg::REG_FLOW_INDEX,
                              48'($signed($urandom) >>> $urandom_range(1, 8)));
                    write_reg(aplv_pkg::REG_MIN_VISC, 48'd1 << $urandom_range(0, 32));
                    write_reg(aplv_pkg::REG_MAX_VISC, 48'd1 << $urandom_range(30, 47));
                end
            endcase
            random_cells(150);
            drain();
        end

        repeat (100) @(posedge clk);
        $display("Covered %0d cells and %0d results over ten register settings,",
                 cells_sent, results_seen);
        $display("including clamps both ways, zero inputs and exponent saturation.");
        if (errors == 0 && expected_visc.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aplv_pkg.sv
rtl/aplv_recip.sv
rtl/aplv_log2.sv
rtl/arrhenius_power_law_viscosity.sv
dv/tb.sv
